// ===== hdl/irsc_pkg.sv =====
package irsc_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_SIZE   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_CRC = 8'd1;

  typedef enum logic [2:0] {
    OP_PREPARE = 3'd0,
    OP_BEGIN   = 3'd1,
    OP_DATA    = 3'd2,
    OP_FINISH  = 3'd3,
    OP_ABORT   = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    SES_IDLE      = 5'b00001,
    SES_READY     = 5'b00010,
    SES_RECEIVING = 5'b00100,
    SES_DONE      = 5'b01000,
    SES_ERROR     = 5'b10000
  } session_t;

  localparam logic [2:0] CODE_IDLE      = 3'd0;
  localparam logic [2:0] CODE_READY     = 3'd1;
  localparam logic [2:0] CODE_RECEIVING = 3'd2;
  localparam logic [2:0] CODE_DONE      = 3'd3;
  localparam logic [2:0] CODE_ERROR     = 3'd4;

  typedef struct packed {
    logic [31:0] image_crc;
    logic [31:0] received_count;
    logic [2:0]  session_state;
    logic        status;
  } result_t;

  function automatic logic [2:0] session_code(input session_t s);
    logic [2:0] code;
    case (s)
      SES_IDLE:      code = CODE_IDLE;
      SES_READY:     code = CODE_READY;
      SES_RECEIVING: code = CODE_RECEIVING;
      SES_DONE:      code = CODE_DONE;
      SES_ERROR:     code = CODE_ERROR;
      default:       code = CODE_IDLE;
    endcase
    return code;
  endfunction

  // reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/irsc_core.sv =====
module irsc_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [irsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              item_accept,
  input  logic [2:0]                        op,
  input  logic [7:0]                        data_byte,
  output irsc_pkg::result_t                 result
);

  irsc_pkg::session_t session_r, session_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] latched_size_r, latched_size_nxt;
  logic [31:0] image_size_r;
  logic [31:0] expected_crc_r;  // held for software, no read path
  logic        fail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r   <= '0;
      expected_crc_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == irsc_pkg::REG_IMAGE_SIZE) begin
        image_size_r <= cfg_data;
      end else if (cfg_index == irsc_pkg::REG_EXPECTED_CRC) begin
        expected_crc_r <= cfg_data;
      end
    end
  end

  always_comb begin
    session_nxt      = session_r;
    count_nxt        = count_r;
    crc_nxt          = crc_r;
    latched_size_nxt = latched_size_r;
    fail             = 1'b0;
    case (irsc_pkg::op_t'(op))
      irsc_pkg::OP_PREPARE: begin
        if (image_size_r == '0) begin
          session_nxt = irsc_pkg::SES_ERROR;
          fail        = 1'b1;
        end else begin
          crc_nxt          = irsc_pkg::ALL_ONES;
          latched_size_nxt = image_size_r;
          count_nxt        = '0;
          session_nxt      = irsc_pkg::SES_READY;
        end
      end
      irsc_pkg::OP_BEGIN: begin
        if (session_r != irsc_pkg::SES_READY) begin
          session_nxt = irsc_pkg::SES_ERROR;
          fail        = 1'b1;
        end else begin
          session_nxt = irsc_pkg::SES_RECEIVING;
        end
      end
      irsc_pkg::OP_DATA: begin
        crc_nxt = irsc_pkg::crc_byte(crc_r, data_byte);
        if (count_r != irsc_pkg::ALL_ONES) begin
          count_nxt = count_r + 32'd1;
        end
        if (count_nxt > latched_size_r) begin
          session_nxt = irsc_pkg::SES_ERROR;
          fail        = 1'b1;
        end
      end
      irsc_pkg::OP_FINISH: begin
        if (session_r != irsc_pkg::SES_RECEIVING && session_r != irsc_pkg::SES_READY) begin
          session_nxt = irsc_pkg::SES_ERROR;
          fail        = 1'b1;
        end else begin
          session_nxt = irsc_pkg::SES_DONE;
        end
      end
      irsc_pkg::OP_ABORT: begin
        session_nxt      = irsc_pkg::SES_IDLE;
        count_nxt        = '0;
        crc_nxt          = '0;
        latched_size_nxt = '0;
      end
      default: begin
        fail = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r      <= irsc_pkg::SES_IDLE;
      count_r        <= '0;
      crc_r          <= '0;
      latched_size_r <= '0;
    end else if (item_accept) begin
      session_r      <= session_nxt;
      count_r        <= count_nxt;
      crc_r          <= crc_nxt;
      latched_size_r <= latched_size_nxt;
    end
  end

  assign result.status         = fail;
  assign result.session_state  = irsc_pkg::session_code(session_nxt);
  assign result.received_count = count_nxt;
  assign result.image_crc      = crc_nxt ^ irsc_pkg::ALL_ONES;

endmodule

// ===== hdl/irsc_skid.sv =====
module irsc_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  irsc_pkg::result_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output irsc_pkg::result_t rd_data
);

  logic              out_valid_r;
  irsc_pkg::result_t out_data_r;
  logic              skid_valid_r;
  irsc_pkg::result_t skid_data_r;
  logic              wr_fire;
  logic              rd_fire;

  assign wr_ready = !skid_valid_r;
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = out_valid_r && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (rd_fire) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (wr_fire) begin
        if (out_valid_r && !rd_ready) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (rd_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (rd_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (wr_fire) begin
      if (out_valid_r && !rd_ready) begin
        skid_data_r <= wr_data;
      end else begin
        out_data_r <= wr_data;
      end
    end
  end

  assign rd_valid = out_valid_r;
  assign rd_data  = out_data_r;

endmodule

// ===== hdl/image_receive_session_crc32_top.sv =====
// Channel  | Direction | Payload
// in_      | slave     | tuser[2:0] op, tdata[7:0] data_byte
// out_     | master    | tdata: status, session_state, received_count, image_crc
// cfg_     | write     | index 0 image size, 1 expected_crc; data 32 bits
//
// One item per cycle while in_tready is high; each result is formed by the
// single pass through the 8-bit CRC update and count compare, then registered.
// rst_n is synchronous, active low; cfg_ready is always high.
// A two-entry output buffer holds results while out_tready is low; in_tready
// drops only when both entries are full.
module image_receive_session_crc32_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic [2:0]                        in_tuser,   // [2:0] op
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] status, [3:1] session_state, [35:4] received_count, [67:36] image_crc
  output logic [irsc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data
);

  irsc_pkg::result_t core_result;
  irsc_pkg::result_t buf_result;
  logic              buf_ready;

  assign cfg_ready = 1'b1;
  assign in_tready = buf_ready;

  irsc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_accept (in_tvalid && buf_ready),
    .op          (in_tuser),
    .data_byte   (in_tdata),
    .result      (core_result)
  );

  irsc_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (buf_ready),
    .wr_data  (core_result),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (buf_result)
  );

  assign out_tdata = {{(irsc_pkg::OUT_TDATA_W - $bits(irsc_pkg::result_t)){1'b0}}, buf_result};

endmodule

// ===== hdl/irsc_checker.sv =====
module irsc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [irsc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // idle is reached only by reset or abort, both clear count and crc
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:1] == irsc_pkg::CODE_IDLE |->
      out_tdata[35:4] == 32'd0 && out_tdata[67:36] == irsc_pkg::ALL_ONES)
    else $error("idle result with nonzero count or crc");

endmodule

bind image_receive_session_crc32_top irsc_checker u_irsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
